// ----- rtl/core/stack_with_value_delete_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Stack with value delete - assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_VALUE_DELETE_UNIT_DEFINES_SVH
`define STACK_WITH_VALUE_DELETE_UNIT_DEFINES_SVH

// property must hold at every edge outside reset
`define SWVD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// when trig holds, prop must hold in the cycle after
`define SWVD_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) else $error(msg);

`endif

// ----- rtl/core/swvd_pkg.sv -----
// ----------------------------------------------------------------------------
// Stack with value delete - package
// Depth, derived widths, operation codes and shared types.
// ----------------------------------------------------------------------------
package swvd_pkg;

	// stack depth and derived widths
	localparam int DEPTH = 8;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	// field widths on the stream ports
	localparam int OP_W       = 2;
	localparam int WORD_W     = 32;
	localparam int FIELD_CNT_W = 4;
	localparam int OUT_BITS   = WORD_W + 1 + FIELD_CNT_W + 1 + 1 + FIELD_CNT_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH      = 2'd0,
		OP_POP       = 2'd1,
		OP_DEL_FIRST = 2'd2,
		OP_DEL_ALL   = 2'd3
	} op_t;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef word_t entry_arr_t [DEPTH];

	// result of one stack operation
	typedef struct packed {
		word_t            top_value;
		logic             top_valid;
		logic [CNT_W-1:0] count;
		logic             full;
		logic             push_ok;
		logic [CNT_W-1:0] removed;
	} stk_res_t;

	// low bits of a count as carried on the result port
	function automatic logic [FIELD_CNT_W-1:0] fit_cnt(input logic [CNT_W-1:0] c);
		logic [CNT_W+FIELD_CNT_W-1:0] wide;
		wide = {{FIELD_CNT_W{1'b0}}, c};
		return wide[FIELD_CNT_W-1:0];
	endfunction

endpackage

// ----- rtl/core/swvd_compact.sv -----
// ----------------------------------------------------------------------------
// Stack with value delete - compaction network
// Marks matching live entries (first only or all), then packs the survivors
// towards the bottom in order using per-entry prefix counts.
// ----------------------------------------------------------------------------
module swvd_compact (
	input  swvd_pkg::entry_arr_t            entries,
	input  logic [swvd_pkg::CNT_W-1:0]      count,
	input  swvd_pkg::word_t                 key,
	input  logic                            only_first,
	output swvd_pkg::entry_arr_t            packed_entries,
	output logic [swvd_pkg::CNT_W-1:0]      packed_count,
	output logic [swvd_pkg::CNT_W-1:0]      removed
);
	import swvd_pkg::*;

	logic [DEPTH-1:0] live;
	logic [DEPTH-1:0] match;
	logic [DEPTH-1:0] hit;
	logic [DEPTH-1:0] keep;
	logic [DEPTH-1:0] below [DEPTH];
	logic [CNT_W-1:0] dest [DEPTH];

	// live and matching entries
	always_comb begin
		for (int r = 0; r < DEPTH; r++) begin
			live[r]  = CNT_W'(r) < count;
			match[r] = live[r] && (entries[r] == key);
		end
	end

	// first match only: isolate the lowest set bit
	assign hit  = only_first ? (match & (~match + DEPTH'(1))) : match;
	assign keep = live & ~hit;

	// destination slot of each survivor
	always_comb begin
		for (int r = 0; r < DEPTH; r++) begin
			for (int j = 0; j < DEPTH; j++) begin
				below[r][j] = (j < r);
			end
			dest[r] = CNT_W'($countones(keep & below[r]));
		end
	end

	// gather survivors; slots above the new count are don't care
	always_comb begin
		for (int w = 0; w < DEPTH; w++) begin
			packed_entries[w] = entries[w];
			for (int r = 0; r < DEPTH; r++) begin
				if (keep[r] && (dest[r] == CNT_W'(w))) begin
					packed_entries[w] = entries[r];
				end
			end
		end
	end

	assign packed_count = CNT_W'($countones(keep));
	assign removed      = CNT_W'($countones(hit));

endmodule

// ----- rtl/core/swvd_stack.sv -----
// ----------------------------------------------------------------------------
// Stack with value delete - stack state and operation datapath
// Holds the entry registers and fill count, applies one operation per
// enabled cycle and forms the result of that operation.
// ----------------------------------------------------------------------------
module swvd_stack (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  swvd_pkg::op_t        op,
	input  swvd_pkg::word_t      value,
	output swvd_pkg::stk_res_t   res
);
	import swvd_pkg::*;

	entry_arr_t       entries_q;
	logic [CNT_W-1:0] count_q;

	entry_arr_t       nxt_entries;
	logic [CNT_W-1:0] nxt_count;
	logic             push_ok;
	logic [CNT_W-1:0] removed;
	logic [CNT_W-1:0] top_pos;

	entry_arr_t       cmp_entries;
	logic [CNT_W-1:0] cmp_count;
	logic [CNT_W-1:0] cmp_removed;

	swvd_compact u_compact (
		.entries        (entries_q),
		.count          (count_q),
		.key            (value),
		.only_first     (op == OP_DEL_FIRST),
		.packed_entries (cmp_entries),
		.packed_count   (cmp_count),
		.removed        (cmp_removed)
	);

	// next state per operation
	always_comb begin
		nxt_entries = entries_q;
		nxt_count   = count_q;
		push_ok     = 1'b0;
		removed     = '0;
		case (op)
			OP_PUSH: begin
				if (count_q < DEPTH_CNT) begin
					nxt_entries[count_q[IDX_W-1:0]] = value;
					nxt_count = count_q + CNT_W'(1);
					push_ok   = 1'b1;
				end
			end
			OP_POP: begin
				if (count_q != '0) begin
					nxt_count = count_q - CNT_W'(1);
					removed   = CNT_W'(1);
				end
			end
			OP_DEL_FIRST, OP_DEL_ALL: begin
				nxt_entries = cmp_entries;
				nxt_count   = cmp_count;
				removed     = cmp_removed;
			end
			default: begin
				nxt_count = count_q;
			end
		endcase
	end

	// result fields from the updated stack
	assign top_pos = nxt_count - CNT_W'(1);

	always_comb begin
		res.top_value = (nxt_count != '0) ? nxt_entries[top_pos[IDX_W-1:0]] : '0;
		res.top_valid = (nxt_count != '0);
		res.count     = nxt_count;
		res.full      = (nxt_count == DEPTH_CNT);
		res.push_ok   = push_ok;
		res.removed   = removed;
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= nxt_count;
		end
	end

	// entry words, read only once written
	always_ff @(posedge clk) begin
		if (en) begin
			entries_q <= nxt_entries;
		end
	end

endmodule

// ----- rtl/core/stack_with_value_delete_unit.sv -----
// ----------------------------------------------------------------------------
// Stack with value delete - top level
// Stream wrapper: input register, stack datapath, registered result.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. Each operation (push, pop,
// delete first match from the bottom, delete all matches) is captured in an
// input register; the stack's entry registers are then read, updated and
// written back when the input register advances, and the result lands in an
// output register at that point, from which it is presented until taken.
// The read-modify-write of the entry registers sets the rate of one
// transaction per clock, which is kept while the output side takes results;
// the output register lets a new transaction be accepted while a finished
// result waits.
// ----------------------------------------------------------------------------
module stack_with_value_delete_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// slave side
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [31:0]                        s_tdata,  // [31:0] value
	input  logic [1:0]                         s_tuser,  // [1:0] op
	// master side
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [31:0] top_value, [32] top_valid, [36:33] entry_count, [37] is_full,
	// [38] push_accepted, [42:39] removed_count, rest zero
	output logic [swvd_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import swvd_pkg::*;
	`include "stack_with_value_delete_unit_defines.svh"

	logic     valid_s1;
	op_t      op_s1;
	word_t    value_s1;
	logic     advance;
	stk_res_t stk_res;
	stk_res_t res_q;
	logic     m_valid_q;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input register, payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= op_t'(s_tuser);
			value_s1 <= s_tdata;
		end
	end

	swvd_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.op     (op_s1),
		.value  (value_s1),
		.res    (stk_res)
	);

	// result register, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// result register, payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= stk_res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {
		{OUT_PAD_W{1'b0}},
		fit_cnt(res_q.removed),
		res_q.push_ok,
		res_q.full,
		fit_cnt(res_q.count),
		res_q.top_valid,
		res_q.top_value
	};

	// checks on the result register
	`SWVD_ASSERT(a_count_bound, !m_valid_q || (res_q.count <= DEPTH_CNT), "count above depth")
	`SWVD_ASSERT(a_top_valid, !m_valid_q || (res_q.top_valid == (res_q.count != '0)), "top_valid disagrees with count")
	`SWVD_ASSERT(a_full_flag, !m_valid_q || (res_q.full == (res_q.count == DEPTH_CNT)), "full flag disagrees with count")
	`SWVD_ASSERT_NEXT(a_push_top, advance && (op_s1 == OP_PUSH), !res_q.push_ok || (res_q.top_value == $past(value_s1)), "accepted push not on top")

endmodule

// ----- tb/stack_with_value_delete_unit_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stack with value delete - result checker
// Watches both stream channels, keeps its own copy of the stack, predicts
// the status of every accepted operation and compares it with the results.
// ----------------------------------------------------------------------------
module stack_with_value_delete_unit_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [31:0]                     s_tdata,  // [31:0] value
	input  logic [1:0]                      s_tuser,  // [1:0] op
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// [31:0] top_value, [32] top_valid, [36:33] entry_count, [37] is_full,
	// [38] push_accepted, [42:39] removed_count, rest zero
	input  logic [swvd_pkg::OUT_DATA_W-1:0] m_tdata,
	output int                              mismatch_count,
	output int                              results_pending
);
	import swvd_pkg::*;

	// stack status after one operation, laid out as on the result port
	// (last member in the lowest bits)
	typedef struct packed {
		logic [3:0]         removed_count;
		logic               push_accepted;
		logic               is_full;
		logic [3:0]         entry_count;
		logic               top_valid;
		logic signed [31:0] top_value;
	} stack_status_t;

	// model copy of the stack
	word_t       stack_words [DEPTH];
	int unsigned stack_fill;

	stack_status_t expected_status [$];

	// apply one operation to the model stack and return the resulting status
	function automatic stack_status_t apply_stack_op(input op_t op, input word_t key);
		stack_status_t st;
		int unsigned   wr;
		int unsigned   hits;
		st = '0;
		wr = 0;
		hits = 0;
		case (op)
			OP_PUSH: begin
				if (stack_fill < DEPTH) begin
					stack_words[stack_fill] = key;
					stack_fill++;
					st.push_accepted = 1'b1;
				end
			end
			OP_POP: begin
				if (stack_fill > 0) begin
					stack_fill--;
					hits = 1;
				end
			end
			default: begin
				// compaction keeps the order of the survivors
				for (int rd = 0; rd < stack_fill; rd++) begin
					if (stack_words[rd] == key && !(op == OP_DEL_FIRST && hits != 0))
						hits++;
					else begin
						stack_words[wr] = stack_words[rd];
						wr++;
					end
				end
				stack_fill = wr;
			end
		endcase
		st.top_value     = (stack_fill > 0) ? stack_words[stack_fill-1] : '0;
		st.top_valid     = (stack_fill > 0);
		st.entry_count   = 4'(stack_fill);
		st.is_full       = (stack_fill == DEPTH);
		st.removed_count = 4'(hits);
		return st;
	endfunction

	task automatic check_field(input string name, input longint exp_val,
			input longint got_val, inout int errs);
		if (exp_val != got_val) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_val, got_val);
			errs++;
		end
	endtask

	// compare results first, then record the prediction for a new transaction
	always @(posedge clk or negedge arst_n) begin
		stack_status_t exp_st;
		stack_status_t got_st;
		int            errs;
		if (!arst_n) begin
			foreach (stack_words[i])
				stack_words[i] = '0;
			stack_fill = 0;
			expected_status.delete();
			mismatch_count  <= 0;
			results_pending <= 0;
		end else begin
			errs = 0;
			if (m_tvalid && m_tready) begin
				got_st = m_tdata[$bits(stack_status_t)-1:0];
				if (expected_status.size() == 0) begin
					$error("result transaction with no operation outstanding");
					errs++;
				end else begin
					exp_st = expected_status.pop_front();
					check_field("top_value", exp_st.top_value, got_st.top_value, errs);
					check_field("top_valid", exp_st.top_valid, got_st.top_valid, errs);
					check_field("entry_count", exp_st.entry_count, got_st.entry_count,
						errs);
					check_field("is_full", exp_st.is_full, got_st.is_full, errs);
					check_field("push_accepted", exp_st.push_accepted,
						got_st.push_accepted, errs);
					check_field("removed_count", exp_st.removed_count,
						got_st.removed_count, errs);
				end
			end
			if (s_tvalid && s_tready)
				expected_status.push_back(apply_stack_op(op_t'(s_tuser), word_t'(s_tdata)));
			mismatch_count  <= mismatch_count + errs;
			results_pending <= expected_status.size();
		end
	end

endmodule

// ----- tb/stack_with_value_delete_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stack with value delete - testbench top
// Drives directed and random stack operations with random idling on both
// sides, lets the checker predict and compare, and gives the verdict.
// ----------------------------------------------------------------------------
module stack_with_value_delete_unit_tb;
	import swvd_pkg::*;

	localparam int RX_HOLD_CYCLES = 48;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata = '0;   // [31:0] value
	logic [1:0]            s_tuser = OP_PUSH;  // [1:0] op
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [31:0] top_value, [32] top_valid, [36:33] entry_count, [37] is_full,
	// [38] push_accepted, [42:39] removed_count, rest zero
	logic [OUT_DATA_W-1:0] m_tdata;

	int mismatch_count;
	int results_pending;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	stack_with_value_delete_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	stack_with_value_delete_unit_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	// result side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= RX_HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("stack_with_value_delete_unit_tb: FAIL");
			$finish;
		end
	end

	// offer one operation, with random gaps before it; returns at the accepting edge
	task automatic send_op(input op_t op, input word_t key);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= key;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// stop offering and wait until every outstanding result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (results_pending != 0);
	endtask

	// random operations; keys mostly from a small pool so deletes find matches
	task automatic send_random_ops(input int n);
		word_t pool [4];
		op_t   op;
		word_t key;
		int    pick;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0) begin
				foreach (pool[i])
					pool[i] = word_t'($urandom);
				pool[$urandom_range(3)] = word_t'($urandom_range(3));
			end
			pick = $urandom_range(99);
			if (pick < 45)
				op = OP_PUSH;
			else if (pick < 65)
				op = OP_POP;
			else if (pick < 83)
				op = OP_DEL_FIRST;
			else
				op = OP_DEL_ALL;
			if ($urandom_range(99) < 65)
				key = pool[$urandom_range(3)];
			else
				key = word_t'($urandom);
			send_op(op, key);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles a little, receiver a lot
		tx_idle_pct = 26;
		rx_idle_pct = 73;

		// empty stack: pop and deletes do nothing
		send_op(OP_POP, 32'sd5);
		send_op(OP_DEL_FIRST, 32'sd5);
		send_op(OP_DEL_ALL, 32'sd5);
		// fill to full with extremes and duplicates
		send_op(OP_PUSH, 32'h8000_0000);
		send_op(OP_PUSH, 32'h7fff_ffff);
		send_op(OP_PUSH, 32'h0000_0000);
		send_op(OP_PUSH, 32'hffff_ffff);
		send_op(OP_PUSH, 32'sd7);
		send_op(OP_PUSH, 32'hffff_ffff);
		send_op(OP_PUSH, 32'sd7);
		send_op(OP_PUSH, 32'h7fff_ffff);
		// push when full is dropped
		send_op(OP_PUSH, 32'sd123);
		// first match from the bottom only, then a miss
		send_op(OP_DEL_FIRST, 32'sd7);
		send_op(OP_DEL_FIRST, 32'sd99);
		// delete all, including the top entry
		send_op(OP_DEL_ALL, 32'hffff_ffff);
		send_op(OP_DEL_ALL, 32'h7fff_ffff);
		// pop down to empty
		send_op(OP_POP, 32'sd0);
		send_op(OP_POP, 32'sd0);
		send_op(OP_POP, 32'sd0);
		// delete all that empties the stack
		send_op(OP_PUSH, 32'haaaa_aaaa);
		send_op(OP_PUSH, 32'haaaa_aaaa);
		send_op(OP_PUSH, 32'haaaa_aaaa);
		send_op(OP_DEL_ALL, 32'haaaa_aaaa);
		// delete first on a single entry
		send_op(OP_PUSH, 32'h5555_5555);
		send_op(OP_DEL_FIRST, 32'h5555_5555);

		send_random_ops(260);
		drain_results();

		// receiver idles a little, sender a lot
		tx_idle_pct = 73;
		rx_idle_pct = 26;
		send_random_ops(280);
		drain_results();

		// no idling; a long hold-off on the result side backs up the input
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_requests <= hold_requests + 1;
		send_random_ops(290);
		drain_results();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_pending == 0)
			$display("stack_with_value_delete_unit_tb: PASS");
		else
			$display("stack_with_value_delete_unit_tb: FAIL");
		$finish;
	end

endmodule
